// ===== design/assert_macros.svh =====
// Assertion helpers used by the limiter design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define PSOL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion violated");

// The condition never holds at a clock edge outside reset.
`define PSOL_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/psol_pkg.sv =====
package psol_pkg;

  localparam int CNT_W       = 5;
  localparam int KEY_W       = 16;
  localparam int TAG_FIELD_W = 8;
  localparam int TOT_FIELD_W = 9;

  localparam logic [CNT_W-1:0] MAX_OUTSTANDING_RESET = 5'd4;

  localparam int STREAM_ENTRIES_DEF = 16;
  localparam int WAIT_DEPTH_DEF     = 16;
  localparam int TAG_COUNT_DEF      = 256;

  typedef enum logic {
    OP_PUSH     = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_FORWARD = 3'd0,
    ST_BUFFER  = 3'd1,
    ST_RELEASE = 3'd2,
    ST_DONE    = 3'd3,
    ST_IGNORE  = 3'd4,
    ST_DROP    = 3'd5,
    ST_ZERO    = 3'd6
  } status_e;

  typedef struct packed {
    op_e                    operation;
    logic [KEY_W-1:0]       stream_key;
    logic [TAG_FIELD_W-1:0] request_tag;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic                   send_valid;
    logic [TAG_FIELD_W-1:0] send_tag;
    logic [CNT_W-1:0]       outstanding_now;
    logic [TOT_FIELD_W-1:0] total_waiting;
  } out_item_t;

  // Result of a key lookup in the stream table.
  typedef struct packed {
    logic hit;
    logic has_free;
  } lookup_t;

  // Update of one stream table entry.
  typedef struct packed {
    logic set;
    logic clr;
  } tbl_upd_t;

endpackage

// ===== design/psol_ram.sv =====
module psol_ram
  import psol_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/psol_stream_table.sv =====
module psol_stream_table
  import psol_pkg::*;
#(
  parameter int STREAM_ENTRIES = STREAM_ENTRIES_DEF,
  localparam int SE_W = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KEY_W-1:0] lookup_key_i,
  output lookup_t          lookup_o,
  output logic [SE_W-1:0]  hit_idx_o,
  output logic [SE_W-1:0]  free_idx_o,
  input  tbl_upd_t         upd_i,
  input  logic [SE_W-1:0]  upd_idx_i,
  input  logic [KEY_W-1:0] upd_key_i
);

  logic             valid_q [STREAM_ENTRIES];
  logic [KEY_W-1:0] key_q   [STREAM_ENTRIES];

  // Lowest matching entry wins, and the lowest free entry is offered.
  always_comb begin
    lookup_o   = '0;
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = STREAM_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == lookup_key_i)) begin
        lookup_o.hit = 1'b1;
        hit_idx_o    = SE_W'(i);
      end
      if (!valid_q[i]) begin
        lookup_o.has_free = 1'b1;
        free_idx_o        = SE_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STREAM_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (upd_i.set) begin
      valid_q[upd_idx_i] <= 1'b1;
    end else if (upd_i.clr) begin
      valid_q[upd_idx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.set) begin
      key_q[upd_idx_i] <= upd_key_i;
    end
  end

endmodule

// ===== design/per_stream_outstanding_request_limiter.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg      input      cfg_we_i                  cfg_wdata_i (max_outstanding)
//
// A push is taken in S_IDLE, where the transfer reads the stream state and tag
// memories; S_READ then decides and writes back. A completion that releases a
// waiting tag passes through S_POP as well, after S_READ has read the wait memory.
// After reset the tag memory is cleared one tag per cycle while in_stall_o stays
// high. A stalled output holds the block in its final state, S_READ or S_POP,
// until the result register is free.
`include "assert_macros.svh"

module per_stream_outstanding_request_limiter
  import psol_pkg::*;
#(
  parameter int STREAM_ENTRIES = STREAM_ENTRIES_DEF,
  parameter int WAIT_DEPTH     = WAIT_DEPTH_DEF,
  parameter int TAG_COUNT      = TAG_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int SE_W     = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
  localparam int HD_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WC_W     = $clog2(WAIT_DEPTH + 1);
  localparam int SL_W     = WC_W + 1;
  localparam int TAG_W    = $clog2(TAG_COUNT);
  localparam int WS_DEPTH = STREAM_ENTRIES * WAIT_DEPTH;
  localparam int WS_W     = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int TOT_W    = $clog2(WS_DEPTH + 1);
  localparam int SW       = CNT_W + HD_W + WC_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_POP
  } state_e;

  state_e    state_q, state_d;
  out_item_t out_q, res;
  logic      out_valid_q, out_valid_d;
  logic      res_fire, out_free, in_accept;

  in_item_t         req_q;
  logic             hit_q, ent_ok_q;
  logic [SE_W-1:0]  e_q;
  logic [CNT_W-1:0] max_q;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic             clr_q;
  logic [TAG_W-1:0] clr_idx_q;

  // Stream table.
  lookup_t         lk;
  logic [SE_W-1:0] lk_hit_idx, lk_free_idx;
  tbl_upd_t        upd;

  // Memory ports.
  logic             st_we;
  logic [SW-1:0]    st_wdata, st_rdata;
  logic             ws_we, ws_re;
  logic [WS_W-1:0]  ws_waddr, ws_raddr;
  logic [TAG_FIELD_W-1:0] ws_rdata;
  logic             tg_we, tg_wdata, fsm_tg_we, fsm_tg_wdata, tg_rdata;
  logic [TAG_W-1:0] tg_waddr, fsm_tg_waddr;

  // Decode of the stream state word read for the current item.
  logic [CNT_W-1:0] rd_cnt, cur_cnt, new_cnt, dec_cnt;
  logic [HD_W-1:0]  rd_hd, cur_hd, hd_inc, slot;
  logic [WC_W-1:0]  rd_wc, cur_wc, new_wc;
  logic [SL_W-1:0]  slot_sum;
  logic [WS_W-1:0]  ws_base;
  logic             tag_ok, tag_known, pop_ok;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || clr_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  psol_stream_table #(
    .STREAM_ENTRIES(STREAM_ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_key_i(in_data_i.stream_key),
    .lookup_o    (lk),
    .hit_idx_o   (lk_hit_idx),
    .free_idx_o  (lk_free_idx),
    .upd_i       (upd),
    .upd_idx_i   (e_q),
    .upd_key_i   (req_q.stream_key)
  );

  // Per-stream in-flight count, FIFO head and FIFO fill.
  psol_ram #(
    .WIDTH(SW),
    .DEPTH(STREAM_ENTRIES)
  ) u_stream_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(e_q),
    .wdata_i(st_wdata),
    .re_i   (in_accept),
    .raddr_i(lk_hit_idx),
    .rdata_o(st_rdata)
  );

  // Waiting tags, one FIFO of WAIT_DEPTH slots per stream entry.
  psol_ram #(
    .WIDTH(TAG_FIELD_W),
    .DEPTH(WS_DEPTH)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (ws_we),
    .waddr_i(ws_waddr),
    .wdata_i(req_q.request_tag),
    .re_i   (ws_re),
    .raddr_i(ws_raddr),
    .rdata_o(ws_rdata)
  );

  // In-flight flag per tag.
  psol_ram #(
    .WIDTH(1),
    .DEPTH(TAG_COUNT)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tg_we),
    .waddr_i(tg_waddr),
    .wdata_i(tg_wdata),
    .re_i   (in_accept),
    .raddr_i(TAG_W'(in_data_i.request_tag)),
    .rdata_o(tg_rdata)
  );

  assign tg_we    = clr_q ? 1'b1 : fsm_tg_we;
  assign tg_waddr = clr_q ? clr_idx_q : fsm_tg_waddr;
  assign tg_wdata = clr_q ? 1'b0 : fsm_tg_wdata;

  assign rd_cnt = st_rdata[SW-1 -: CNT_W];
  assign rd_hd  = st_rdata[HD_W+WC_W-1 -: HD_W];
  assign rd_wc  = st_rdata[WC_W-1:0];

  // A stream without an entry starts from an empty state.
  assign cur_cnt = hit_q ? rd_cnt : '0;
  assign cur_hd  = hit_q ? rd_hd : '0;
  assign cur_wc  = hit_q ? rd_wc : '0;

  assign slot_sum = SL_W'(cur_hd) + SL_W'(cur_wc);
  assign slot     = (slot_sum >= SL_W'(WAIT_DEPTH)) ?
                    HD_W'(slot_sum - SL_W'(WAIT_DEPTH)) : HD_W'(slot_sum);
  assign hd_inc   = (rd_hd == HD_W'(WAIT_DEPTH - 1)) ? '0 : rd_hd + 1'b1;
  assign ws_base  = WS_W'(e_q) * WS_W'(WAIT_DEPTH);
  assign dec_cnt  = rd_cnt - 1'b1;

  assign tag_ok    = 32'(req_q.request_tag) < TAG_COUNT;
  assign tag_known = tag_ok && tg_rdata;
  assign pop_ok    = 32'(ws_rdata) < TAG_COUNT;

  always_comb begin
    state_d      = state_q;
    tot_d        = tot_q;
    res_fire     = 1'b0;
    upd          = '0;
    st_we        = 1'b0;
    st_wdata     = '0;
    ws_we        = 1'b0;
    ws_waddr     = ws_base + WS_W'(slot);
    ws_re        = 1'b0;
    ws_raddr     = ws_base + WS_W'(rd_hd);
    fsm_tg_we    = 1'b0;
    fsm_tg_waddr = TAG_W'(req_q.request_tag);
    fsm_tg_wdata = 1'b0;
    new_cnt      = cur_cnt;
    new_wc       = cur_wc;
    res          = '0;
    res.status   = ST_IGNORE;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (req_q.operation == OP_PUSH) begin
          if (out_free) begin
            res_fire = 1'b1;
            state_d  = S_IDLE;
            if (!ent_ok_q) begin
              res.status = ST_DROP;
            end else if (cur_cnt < max_q) begin
              new_cnt        = cur_cnt + 1'b1;
              fsm_tg_we      = tag_ok;
              fsm_tg_wdata   = 1'b1;
              res.status     = ST_FORWARD;
              res.send_valid = 1'b1;
              res.send_tag   = req_q.request_tag;
            end else if (cur_wc >= WC_W'(WAIT_DEPTH)) begin
              res.status = ST_DROP;
            end else begin
              ws_we      = 1'b1;
              new_wc     = cur_wc + 1'b1;
              tot_d      = tot_q + 1'b1;
              res.status = ST_BUFFER;
            end
            if (res.status != ST_DROP) begin
              upd.set  = 1'b1;
              st_we    = 1'b1;
              st_wdata = {new_cnt, cur_hd, new_wc};
            end
            // A dropped push of a new stream reports no count.
            res.outstanding_now = (res.status == ST_DROP && !hit_q) ? '0 : new_cnt;
          end
        end else if (!tag_known) begin
          if (out_free) begin
            res_fire            = 1'b1;
            state_d             = S_IDLE;
            res.status          = ST_IGNORE;
            res.outstanding_now = cur_cnt;
          end
        end else if (!hit_q || (rd_cnt == '0)) begin
          if (out_free) begin
            res_fire   = 1'b1;
            state_d    = S_IDLE;
            fsm_tg_we  = 1'b1;
            res.status = ST_ZERO;
          end
        end else if (rd_wc != '0) begin
          // The count drops and rises again; only the FIFO moves on.
          fsm_tg_we = 1'b1;
          ws_re     = 1'b1;
          st_we     = 1'b1;
          st_wdata  = {rd_cnt, hd_inc, rd_wc - 1'b1};
          tot_d     = tot_q - 1'b1;
          state_d   = S_POP;
        end else if (out_free) begin
          res_fire            = 1'b1;
          state_d             = S_IDLE;
          fsm_tg_we           = 1'b1;
          st_we               = 1'b1;
          res.status          = ST_DONE;
          res.outstanding_now = dec_cnt;
          if (dec_cnt == '0) begin
            upd.clr  = 1'b1;
            st_wdata = '0;
          end else begin
            st_wdata = {dec_cnt, rd_hd, WC_W'(0)};
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          res_fire            = 1'b1;
          state_d             = S_IDLE;
          fsm_tg_we           = pop_ok;
          fsm_tg_waddr        = TAG_W'(ws_rdata);
          fsm_tg_wdata        = 1'b1;
          res.status          = ST_RELEASE;
          res.send_valid      = 1'b1;
          res.send_tag        = ws_rdata;
          res.outstanding_now = rd_cnt;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.total_waiting = TOT_FIELD_W'(tot_d);
    out_valid_d = res_fire ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (res_fire) begin
        out_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= in_data_i;
      hit_q    <= lk.hit;
      ent_ok_q <= lk.hit || lk.has_free;
      e_q      <= lk.hit ? lk_hit_idx : lk_free_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else begin
      tot_q <= tot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_OUTSTANDING_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Clearing pass over the tag memory after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == TAG_W'(TAG_COUNT - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  `PSOL_ASSERT_NEVER(a_result_overwrite, clk_i, rst_ni, res_fire && out_valid_q && out_stall_i)
  `PSOL_ASSERT(a_total_bounded, clk_i, rst_ni, 32'(tot_q) <= WS_DEPTH)
  `PSOL_ASSERT(a_pop_after_read, clk_i, rst_ni, (state_q == S_POP) |-> ($past(state_q) == S_READ || $past(state_q) == S_POP))
  `PSOL_ASSERT(a_accept_to_read, clk_i, rst_ni, in_accept |=> (state_q == S_READ))

endmodule
